// ----- src/plbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package plbt_pkg;

    localparam int CHANNELS      = 16;
    localparam int MAX_LEDS      = 256;
    localparam int COLOR_W       = 24;
    localparam int SLOT_W        = 16;
    localparam int SLOTS         = 24;
    localparam int LED_CFG_W     = 9;
    localparam int POS_W         = 8;
    localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_CNT_W    = $clog2(SLOTS);
    localparam int LED_CAP       = (MAX_LEDS < 256) ? MAX_LEDS : 256;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [LED_CFG_W-1:0] LED_COUNT_RESET = LED_CFG_W'(256);
    localparam logic [LED_CFG_W-1:0] LED_COUNT_CAP   = LED_CFG_W'(LED_CAP);
    localparam logic [CH_W-1:0]      LAST_CHANNEL    = CH_W'(CHANNELS - 1);
    localparam logic [SLOT_CNT_W-1:0] LAST_SLOT      = SLOT_CNT_W'(SLOTS - 1);

    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] REG_LED_COUNT = 3'd0;

    typedef logic [CHANNELS-1:0][COLOR_W-1:0] t_store;

    typedef struct packed {
        t_store words;
        logic   frame_end;
    } t_led;

endpackage
`default_nettype wire

// ----- src/plbt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbt_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [plbt_pkg::COLOR_W-1:0]     i_color,
    input  wire  [plbt_pkg::LED_CFG_W-1:0]   i_led_count,
    output logic                             o_push,
    output plbt_pkg::t_led                   o_push_led,
    input  wire                              i_full
);
    import plbt_pkg::*;

    t_store                 r_store;
    logic [CH_W-1:0]        r_chan;
    logic [POS_W-1:0]       r_pos;
    logic [LED_CFG_W-1:0]   eff_leds;
    logic                   last_chan;
    logic                   frame_end;
    logic                   accept;

    always_comb begin
        if (i_led_count == '0) begin
            eff_leds = LED_CFG_W'(1);
        end else if (i_led_count > LED_COUNT_CAP) begin
            eff_leds = LED_COUNT_CAP;
        end else begin
            eff_leds = i_led_count;
        end
    end

    assign last_chan = (r_chan == LAST_CHANNEL);
    assign frame_end = ({1'b0, r_pos} + LED_CFG_W'(1)) >= eff_leds;
    // hold the last channel of a position until the queue has room
    assign o_ready   = !last_chan || !i_full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && last_chan;

    always_comb begin
        o_push_led.words            = r_store;
        o_push_led.words[r_chan]    = i_color;
        o_push_led.frame_end        = frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store[r_chan] <= i_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_pos  <= '0;
        end else if (accept) begin
            if (last_chan) begin
                r_chan <= '0;
                r_pos  <= frame_end ? '0 : r_pos + POS_W'(1);
            end else begin
                r_chan <= r_chan + CH_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/plbt_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbt_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  plbt_pkg::t_led   i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output plbt_pkg::t_led   o_data
);
    import plbt_pkg::*;

    t_led                 r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    r_wptr;
    logic [QPTR_W-1:0]    r_rptr;
    logic [QPTR_W:0]      r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/plbt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plbt_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_valid,
    input  plbt_pkg::t_led                 i_q_data,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [plbt_pkg::SLOT_W-1:0]    o_slot_word,
    output logic                           o_last_of_led,
    output logic                           o_last_of_frame
);
    import plbt_pkg::*;

    t_store                  r_words;
    logic                    r_frame;
    logic                    r_active;
    logic [SLOT_CNT_W-1:0]   r_slot;
    logic                    r_valid;
    logic [SLOT_W-1:0]       r_slot_word;
    logic                    r_last_led;
    logic                    r_last_frame;
    logic                    advance;
    logic                    last_slot;
    logic [SLOT_W-1:0]       n_slot_word;

    assign advance   = !r_valid || i_ready;
    assign last_slot = (r_slot == LAST_SLOT);
    assign o_pop     = !r_active && i_q_valid;

    always_comb begin
        n_slot_word = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            n_slot_word[k] = r_words[k][COLOR_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_words <= i_q_data.words;
            r_frame <= i_q_data.frame_end;
        end else if (advance && r_active) begin
            // advance every channel to its next bit
            for (int k = 0; k < CHANNELS; k++) begin
                r_words[k] <= {r_words[k][COLOR_W-2:0], 1'b0};
            end
        end
        if (advance && r_active) begin
            r_slot_word  <= n_slot_word;
            r_last_led   <= last_slot;
            r_last_frame <= last_slot && r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_slot   <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_slot   <= '0;
            end else if (advance && r_active) begin
                r_slot <= last_slot ? '0 : r_slot + SLOT_CNT_W'(1);
                if (last_slot) begin
                    r_active <= 1'b0;
                end
            end
            if (advance) begin
                r_valid <= r_active;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_slot_word     = r_slot_word;
    assign o_last_of_led   = r_last_led;
    assign o_last_of_frame = r_last_frame;

endmodule
`default_nettype wire

// ----- src/parallel_led_bit_transposer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// s_*       in         tdata[23:0] color
// m_*       out        tdata[15:0] slot_word, tlast last_of_led, tuser[0] last_of_frame
// APB       in/out     register 0 at byte 0: led_count[8:0]
//
// A colour beat is taken every cycle while the queue has room; the last channel of
// a position waits only when both queue entries are full.
// Each LED position gives 24 slot beats, one per cycle from the output register while
// m_tready stays high; the next position loads from the queue once the last slot has
// entered the output register, and the front keeps filling the queue meanwhile.
// Synchronous reset clears counters, queue and output valid; led_count resets to 256.
// A stall on m_tready holds the output register and the slot shifter only.
module parallel_led_bit_transposer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [plbt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [plbt_pkg::COLOR_W-1:0]        s_tdata,   // [23:0] color
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [plbt_pkg::SLOT_W-1:0]         m_tdata,   // [15:0] slot_word
    output logic                                m_tlast,   // last_of_led
    output logic                                m_tuser    // [0] last_of_frame
);
    import plbt_pkg::*;

    logic [LED_CFG_W-1:0]  r_led_count;
    logic                  push;
    t_led                  push_led;
    logic                  q_full;
    logic                  q_valid;
    t_led                  q_data;
    logic                  pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LED_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_LED_COUNT)) begin
            r_led_count <= pwdata[LED_CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_LED_COUNT) begin
            prdata = {{(32-LED_CFG_W){1'b0}}, r_led_count};
        end
    end

    plbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_color     (s_tdata),
        .i_led_count (r_led_count),
        .o_push      (push),
        .o_push_led  (push_led),
        .i_full      (q_full)
    );

    plbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_led),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    plbt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_pop           (pop),
        .o_valid         (m_tvalid),
        .i_ready         (m_tready),
        .o_slot_word     (m_tdata),
        .o_last_of_led   (m_tlast),
        .o_last_of_frame (m_tuser)
    );

endmodule
`default_nettype wire

// ----- tb/sv/slot_transpose_checker.sv -----
`timescale 1ns / 1ps
module slot_transpose_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_psel,
    input  wire                              i_penable,
    input  wire                              i_pwrite,
    input  wire                              i_pready,
    input  wire  [plbt_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  wire  [31:0]                      i_pwdata,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire  [plbt_pkg::COLOR_W-1:0]     i_s_tdata,   // [23:0] color
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [plbt_pkg::SLOT_W-1:0]      i_m_tdata,   // [15:0] slot_word
    input  wire                              i_m_tlast,   // last_of_led
    input  wire                              i_m_tuser,   // [0] last_of_frame
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_slots_checked,
    output int                               o_frame_ends
);
    import plbt_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_word;
        logic              last_of_led;
        logic              last_of_frame;
    } t_slot;

    logic [COLOR_W-1:0]   colours [CHANNELS];
    logic [CH_W-1:0]      channel;
    logic [POS_W-1:0]     position;
    logic [LED_CFG_W-1:0] led_count;
    t_slot                slots_due [$];

    // Store one colour; on the last channel queue the 24 transposed slots.
    task automatic take_colour(input logic [COLOR_W-1:0] colour);
        int    leds;
        logic  frame_end;
        t_slot slot;
        colours[channel] = colour;
        if (channel != LAST_CHANNEL) begin
            channel = channel + CH_W'(1);
            return;
        end
        leds = (led_count == '0) ? 1 : int'(led_count);
        if (leds > LED_CAP)
            leds = LED_CAP;
        frame_end = (int'(position) + 1 >= leds);
        for (int b = 0; b < SLOTS; b++) begin
            slot.slot_word = '0;
            for (int k = 0; k < CHANNELS; k++)
                slot.slot_word[k] = colours[k][COLOR_W-1-b];
            slot.last_of_led   = (b == SLOTS - 1);
            slot.last_of_frame = (b == SLOTS - 1) && frame_end;
            slots_due.push_back(slot);
        end
        if (frame_end)
            o_frame_ends++;
        channel  = '0;
        position = frame_end ? '0 : position + POS_W'(1);
    endtask

    task automatic check_slot();
        t_slot want;
        if (slots_due.size() == 0) begin
            o_errors++;
            $display("%0t: slot beat with nothing expected: ", $time,
                     "data %h last_of_led %b last_of_frame %b",
                     i_m_tdata, i_m_tlast, i_m_tuser);
            return;
        end
        want = slots_due.pop_front();
        o_slots_checked++;
        if (want.slot_word !== i_m_tdata || want.last_of_led !== i_m_tlast
                || want.last_of_frame !== i_m_tuser) begin
            o_errors++;
            $display("%0t: slot mismatch: ", $time,
                     "expected data %h last_of_led %b last_of_frame %b, ",
                     want.slot_word, want.last_of_led, want.last_of_frame,
                     "got data %h last_of_led %b last_of_frame %b",
                     i_m_tdata, i_m_tlast, i_m_tuser);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            channel   = '0;
            position  = '0;
            led_count = LED_COUNT_RESET;
            slots_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_LED_COUNT)
                led_count = i_pwdata[LED_CFG_W-1:0];
            if (i_m_tvalid && i_m_tready)
                check_slot();
            if (i_s_tvalid && i_s_tready)
                take_colour(i_s_tdata);
        end
        o_pending = slots_due.size();
    end

endmodule

// ----- tb/sv/parallel_led_bit_transposer_tb.sv -----
`timescale 1ns / 1ps
module parallel_led_bit_transposer_tb;
    import plbt_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;
    localparam int SETTLE_CYCLES = 40;
    localparam int SINK_HOLD     = 300;
    localparam int IDLE_LIMIT    = 2000;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_PATTERN} t_sink_mode;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [COLOR_W-1:0]    s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SLOT_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int errors, pending, slots_checked, frame_ends;
    int colour_beats = 0;
    int burst_left   = 0;
    int hold_ask     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    parallel_led_bit_transposer DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    slot_transpose_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_slots_checked (slots_checked),
        .o_frame_ends    (frame_ends)
    );

    // Entered and left at a falling edge.
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one colour beat; drop valid for a random gap between bursts.
    task automatic push_colour(input logic [COLOR_W-1:0] colour);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= colour;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        colour_beats++;
        @(negedge i_clk);
    endtask

    task automatic run_positions(input int count);
        logic [COLOR_W-1:0] colour;
        for (int i = 0; i < count * CHANNELS; i++) begin
            case ($urandom_range(0, 7))
                0:       colour = '0;
                1:       colour = '1;
                default: colour = COLOR_W'($urandom);
            endcase
            push_colour(colour);
        end
    endtask

    // Hold valid low until every slot is out, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Sink: random modes in stretches, plus one long hold on request.
    initial begin
        int         hold_left;
        int         run_left;
        int         hold_seen;
        int         tick;
        t_sink_mode mode;
        logic       ready;
        hold_left = 0;
        run_left  = 0;
        hold_seen = 0;
        tick      = 0;
        mode      = SINK_OPEN;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = SINK_HOLD - 1;
                ready = 1'b0;
            end else begin
                if (run_left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 2));
                    run_left = $urandom_range(8, 64);
                end
                run_left--;
                case (mode)
                    SINK_OPEN: ready = 1'b1;
                    SINK_COIN: ready = 1'($urandom_range(0, 1));
                    default:   ready = (tick % 5) > 1;
                endcase
            end
            m_tready <= ready;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles, %0d slots still due",
                 $time, IDLE_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [COLOR_W-1:0] colour;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Edge values across the channels of one position, reset led_count.
        for (int k = 0; k < CHANNELS; k++) begin
            case (k)
                0:       colour = 24'h800000;
                1:       colour = 24'h000001;
                3:       colour = 24'h000000;
                4:       colour = 24'hAAAAAA;
                5:       colour = 24'h555555;
                6:       colour = 24'hFF0000;
                7:       colour = 24'h00FF00;
                8:       colour = 24'h0000FF;
                10:      colour = 24'h7FFFFE;
                11:      colour = 24'h000000;
                default: colour = 24'hFFFFFF;
            endcase
            push_colour(colour);
        end
        settle();

        // Zero counts as one LED; position counter is past it, so the frame ends.
        apb_write(REG_LED_COUNT, 32'd0);
        run_positions(1);
        settle();

        // Three-LED frames with the sink held off so the input backs up.
        apb_write(REG_LED_COUNT, 32'd3);
        hold_ask <= hold_ask + 1;
        run_positions(4);
        settle();

        apb_write(REG_LED_COUNT, 32'd256);
        run_positions(1);
        settle();

        // Write outside the register map is ignored; all-ones saturates to the cap.
        apb_write(ADDR_UNUSED, 32'd1);
        apb_write(REG_LED_COUNT, 32'hFFFF_FFFF);
        run_positions(1);
        settle();

        // Upper data bits are dropped, leaving two; counter already beyond it.
        apb_write(REG_LED_COUNT, 32'h0000_FE02);
        run_positions(2);
        settle();

        apb_write(REG_LED_COUNT, 32'd1);
        run_positions(1);
        settle();

        $display("Sent %0d colour beats; checked %0d slot beats across %0d frame ends.",
                 colour_beats, slots_checked, frame_ends);
        $display("led_count took 0, 1, 2, 3, 256 and saturated values, with a long sink hold.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/plbt_pkg.sv
src/plbt_front.sv
src/plbt_queue.sv
src/plbt_back.sv
src/parallel_led_bit_transposer.sv
tb/sv/slot_transpose_checker.sv
tb/sv/parallel_led_bit_transposer_tb.sv
